>>> rtl/p2pwa_pkg.sv
// Shared constants for the peak-to-peak window averager.
// Used by the register block, the tracker and the top level; no dependencies.
package p2pwa_pkg;

   // Window length register
   localparam int WL_BITS = 16;
   localparam logic [WL_BITS-1:0] WL_RESET = 16'd1000;

   // APB register map: one register, word addressed
   localparam int APB_ADDR_BITS = 3;
   localparam int APB_DATA_BITS = 32;
   localparam int REG_IDX_BITS = APB_ADDR_BITS - 2;
   localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 1'b0;

endpackage

>>> rtl/p2pwa_if.sv
// Valid/ready channel interfaces for the sample and result streams.
// Depends on nothing; the payload width follows SAMPLE_BITS.
interface p2pwa_req_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface p2pwa_rsp_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] average_span;
   logic                   window_closed;
   logic [SAMPLE_BITS-1:0] latest_span;

   modport source (output valid, output average_span, output window_closed,
                   output latest_span, input ready);
   modport sink   (input valid, input average_span, input window_closed,
                   input latest_span, output ready);
endinterface

>>> rtl/peak_to_peak_window_averager_top.sv
// Peak-to-peak window averager. Each sample transaction yields one result
// transaction, registered through stage one and the output stage, and a new
// sample is taken every cycle unless both stages are full and the result side
// stalls: the state update (min/max, ring write, running sum) completes in the
// accept cycle because the ring entry to be replaced is read ahead from its
// RAM at the current pointer. The average is the running sum times a reciprocal
// of NUM_SPANS, computed in the second stage. There is no clearing pass after
// reset; unwritten ring entries read as zero through per-entry valid bits.
module peak_to_peak_window_averager_top
   import p2pwa_pkg::*;
#(
   parameter int NUM_SPANS   = 10,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   p2pwa_req_if.sink                req_chan,
   p2pwa_rsp_if.source              rsp_chan,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [APB_ADDR_BITS-1:0] paddr,
   input  logic [APB_DATA_BITS-1:0] pwdata,
   output logic [APB_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int SUM_BITS  = SAMPLE_BITS + ((NUM_SPANS > 1) ? $clog2(NUM_SPANS) : 0);
   localparam int DIV_SHIFT = SUM_BITS + 5;
   localparam int PROD_BITS = SUM_BITS + DIV_SHIFT + 1;
   localparam logic [DIV_SHIFT:0] RECIP =
      (DIV_SHIFT + 1)'(((64'd1 << DIV_SHIFT) + 64'(NUM_SPANS) - 64'd1) / 64'(NUM_SPANS));

   logic [WL_BITS-1:0]     window_length;
   logic                   accept;
   logic                   close;
   logic [SAMPLE_BITS-1:0] span;
   logic [SUM_BITS-1:0]    span_sum;
   logic [SAMPLE_BITS-1:0] latest_span;
   logic [PROD_BITS-1:0]   product;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_closed_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_avg_ff;
   logic                   out_closed_ff;
   logic [SAMPLE_BITS-1:0] out_latest_ff;
   logic                   out_adv;
   logic                   s1_adv;

   p2pwa_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .window_length (window_length)
   );

   p2pwa_tracker #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_tracker (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .sample        (req_chan.sample),
      .window_length (window_length),
      .close         (close),
      .span          (span)
   );

   p2pwa_ring #(
      .NUM_SPANS   (NUM_SPANS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .close       (close),
      .span        (span),
      .span_sum    (span_sum),
      .latest_span (latest_span)
   );

   // Stage one holds only the flag; the sum and latest span it refers to are
   // the ring state itself, which cannot move until stage one hands its entry on.
   assign out_adv        = !out_valid_ff || rsp_chan.ready;
   assign s1_adv         = !s1_valid_ff || out_adv;
   assign req_chan.ready = s1_adv;
   assign accept         = req_chan.valid && s1_adv;

   assign product = PROD_BITS'(span_sum) * PROD_BITS'(RECIP);

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_adv) begin
         out_valid_in = s1_valid_ff;
      end
      if (s1_adv) begin
         s1_valid_in = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_closed_ff <= close;
      end
      if (out_adv && s1_valid_ff) begin
         out_avg_ff    <= product[DIV_SHIFT +: SAMPLE_BITS];
         out_closed_ff <= s1_closed_ff;
         out_latest_ff <= latest_span;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.average_span  = out_avg_ff;
   assign rsp_chan.window_closed = out_closed_ff;
   assign rsp_chan.latest_span   = out_latest_ff;

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction not held in stage one");

   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_adv) |=> (s1_valid_ff && $stable(s1_closed_ff)))
      else $error("stage one overwritten while the result side stalls");

   a_no_accept_stalled : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_chan.ready) |-> !accept)
      else $error("sample accepted while both stages are stalled");

endmodule

>>> rtl/p2pwa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module p2pwa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 10,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/p2pwa_csr.sv
// APB register block holding the window length.
// Depends on p2pwa_pkg for the register map and reset value.
module p2pwa_csr
   import p2pwa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [APB_ADDR_BITS-1:0] paddr,
   input  logic [APB_DATA_BITS-1:0] pwdata,
   output logic [APB_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [WL_BITS-1:0]       window_length
);

   logic [WL_BITS-1:0]      wl_ff;
   logic [WL_BITS-1:0]      wl_in;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                    hit;

   assign reg_idx = paddr[APB_ADDR_BITS-1:2];
   assign hit     = (reg_idx == REG_WINDOW_LENGTH);

   always_comb begin
      wl_in = wl_ff;
      if (psel && penable && pwrite && hit) begin
         wl_in = pwdata[WL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= WL_RESET;
      end else begin
         wl_ff <= wl_in;
      end
   end

   assign prdata        = hit ? APB_DATA_BITS'(wl_ff) : '0;
   assign pready        = 1'b1;
   assign window_length = wl_ff;

endmodule

>>> rtl/p2pwa_tracker.sv
// Running maximum, minimum and sample count of the open window.
// Depends on p2pwa_pkg for the window length width.
module p2pwa_tracker
   import p2pwa_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [WL_BITS-1:0]     window_length,
   output logic                   close,
   output logic [SAMPLE_BITS-1:0] span
);

   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [WL_BITS-1:0]     count_ff, count_in;

   // A sample arriving once the count has reached the length closes the window.
   assign close = (count_ff >= window_length);
   // An empty window leaves max below min, and the span then reads as zero.
   assign span  = (max_ff >= min_ff) ? (max_ff - min_ff) : '0;

   always_comb begin
      max_in   = max_ff;
      min_in   = min_ff;
      count_in = count_ff;
      if (accept) begin
         if (close) begin
            max_in   = '0;
            min_in   = '1;
            count_in = '0;
         end else begin
            if (sample > max_ff) begin
               max_in = sample;
            end
            if (sample < min_ff) begin
               min_in = sample;
            end
            count_in = count_ff + WL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= '0;
         min_ff   <= '1;
         count_ff <= '0;
      end else begin
         max_ff   <= max_in;
         min_ff   <= min_in;
         count_ff <= count_in;
      end
   end

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (accept && !close) |=> (count_ff == $past(count_ff) + WL_BITS'(1)))
      else $error("sample count did not advance on a tracked sample");

   a_min_max : assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_ff <= max_ff))
      else $error("running minimum above maximum in a non-empty window");

endmodule

>>> rtl/p2pwa_ring.sv
// Ring of stored spans in a RAM, with pointer, running sum and latest span.
// Depends on p2pwa_ram. The old entry is read ahead at the pointer.
module p2pwa_ring #(
   parameter int NUM_SPANS   = 10,
   parameter int SAMPLE_BITS = 12,
   parameter int SUM_BITS    = 16,
   localparam int PTR_BITS = (NUM_SPANS > 1) ? $clog2(NUM_SPANS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   close,
   input  logic [SAMPLE_BITS-1:0] span,
   output logic [SUM_BITS-1:0]    span_sum,
   output logic [SAMPLE_BITS-1:0] latest_span
);

   logic [PTR_BITS-1:0]    ptr_ff, ptr_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] latest_ff, latest_in;
   logic [NUM_SPANS-1:0]   valid_ff, valid_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   fwd_ff, fwd_in;
   logic [SAMPLE_BITS-1:0] fwd_data_ff;
   logic [SAMPLE_BITS-1:0] ram_q;
   logic [SAMPLE_BITS-1:0] old_span;
   logic                   wr_en;

   assign wr_en = accept && close;

   // The read address follows the next pointer, so the entry about to be
   // overwritten is always waiting at the RAM output. A write to the entry
   // being read in the same cycle is forwarded.
   assign old_span = fwd_ff    ? fwd_data_ff :
                     rd_vld_ff ? ram_q       : '0;

   always_comb begin
      ptr_in    = ptr_ff;
      sum_in    = sum_ff;
      latest_in = latest_ff;
      valid_in  = valid_ff;
      if (wr_en) begin
         ptr_in           = (ptr_ff == PTR_BITS'(NUM_SPANS - 1)) ? '0
                                                                 : ptr_ff + PTR_BITS'(1);
         sum_in           = sum_ff - SUM_BITS'(old_span) + SUM_BITS'(span);
         latest_in        = span;
         valid_in[ptr_ff] = 1'b1;
      end
      rd_vld_in = valid_ff[ptr_in];
      fwd_in    = wr_en && (ptr_ff == ptr_in);
   end

   p2pwa_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (NUM_SPANS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff),
      .wr_data (span),
      .rd_addr (ptr_in),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         sum_ff    <= '0;
         latest_ff <= '0;
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         ptr_ff    <= ptr_in;
         sum_ff    <= sum_in;
         latest_ff <= latest_in;
         valid_ff  <= valid_in;
         rd_vld_ff <= rd_vld_in;
         fwd_ff    <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= span;
   end

   assign span_sum    = sum_ff;
   assign latest_span = latest_ff;

   a_ptr_range : assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_BITS'(NUM_SPANS - 1))
      else $error("ring pointer beyond the last entry");

   a_entry_valid : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(ptr_ff)])
      else $error("written ring entry not marked valid");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the peak-to-peak window averager: streams samples through
// valid/ready channels, writes the window length over APB and predicts every result.
// Depends on p2pwa_pkg, the channel interfaces and peak_to_peak_window_averager_top.
`timescale 1ns / 100ps

module tb_top
   import p2pwa_pkg::*;
();

   localparam int NUM_SPANS      = 10;
   localparam int SAMPLE_BITS    = 12;
   localparam int MAX_SAMPLE     = (1 << SAMPLE_BITS) - 1;
   localparam int LATENCY_CYCLES = 2;
   localparam int CYCLE_LIMIT    = 200000;
   localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED = 1'b1;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef struct packed {
      sample_type average_span;
      logic       window_closed;
      sample_type latest_span;
   } span_result_type;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [APB_ADDR_BITS-1:0] paddr;
   logic [APB_DATA_BITS-1:0] pwdata;
   logic [APB_DATA_BITS-1:0] prdata;
   logic                     pready;

   p2pwa_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   p2pwa_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_chan ();

   peak_to_peak_window_averager_top #(
      .NUM_SPANS   (NUM_SPANS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Predictor state, a copy of what the block should hold
   logic [WL_BITS-1:0] window_len;
   logic [WL_BITS-1:0] window_fill;
   sample_type         peak_hi;
   sample_type         peak_lo;
   sample_type         span_ring [NUM_SPANS];
   int                 ring_slot;
   int                 span_total;

   sample_type      samples_pending[$];
   span_result_type span_results_due[$];
   int              send_idle_pct;
   int              rsp_stall_pct;
   int              rsp_hold_left;
   int              error_count;
   int              cycle_count;
   bit              sample_taken;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic span_result_type track_window_sample(input sample_type value);
      span_result_type res;
      sample_type      span;
      int              last_slot;
      res.window_closed = 1'b0;
      if (window_fill >= window_len) begin
         // The closing sample is not tracked; an empty window gives a zero span.
         span = (peak_hi >= peak_lo) ? sample_type'(peak_hi - peak_lo) : '0;
         span_total = span_total - span_ring[ring_slot] + span;
         span_ring[ring_slot] = span;
         ring_slot = (ring_slot == NUM_SPANS - 1) ? 0 : ring_slot + 1;
         window_fill = '0;
         peak_hi = '0;
         peak_lo = sample_type'(MAX_SAMPLE);
         res.window_closed = 1'b1;
      end else begin
         if (value > peak_hi) peak_hi = value;
         if (value < peak_lo) peak_lo = value;
         window_fill = window_fill + 1'b1;
      end
      last_slot = (ring_slot == 0) ? NUM_SPANS - 1 : ring_slot - 1;
      res.average_span = sample_type'(span_total / NUM_SPANS);
      res.latest_span = span_ring[last_slot];
      return res;
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(7))
         0: return '0;
         1: return sample_type'(MAX_SAMPLE);
         default: return sample_type'($urandom_range(MAX_SAMPLE));
      endcase
   endfunction

   // Sample driver: a transaction stays on the channel until it has been accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || sample_taken) begin
         if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid <= 1'b1;
            req_chan.sample <= samples_pending.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
      sample_taken = 1'b0;
   end

   // Result receiver; a long hold-off is counted down here.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : result_monitor
      span_result_type seen;
      span_result_type due;
      if (!reset && req_chan.valid && req_chan.ready) begin
         span_results_due.push_back(track_window_sample(req_chan.sample));
         sample_taken = 1'b1;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = '{rsp_chan.average_span, rsp_chan.window_closed, rsp_chan.latest_span};
         if (span_results_due.size() == 0) begin
            $display("%0t: unexpected result: avg %0d closed %0d latest %0d",
                     $time, seen.average_span, seen.window_closed, seen.latest_span);
            error_count++;
         end else begin
            due = span_results_due.pop_front();
            if (seen !== due) begin
               // Fields are listed as average, closed flag, latest span.
               $display("%0t: result mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                        $time, due.average_span, due.window_closed, due.latest_span,
                        seen.average_span, seen.window_closed, seen.latest_span);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding",
                  $time, span_results_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx,
                            input logic [APB_DATA_BITS-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_WINDOW_LENGTH) window_len = value[WL_BITS-1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_window_readback();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {REG_WINDOW_LENGTH, 2'b00};
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== APB_DATA_BITS'(window_len)) begin
         $display("%0t: window length readback: expected %0d, got %0d",
                  $time, window_len, prdata);
         error_count++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_window(input logic [APB_DATA_BITS-1:0] value);
      csr_write(REG_WINDOW_LENGTH, value);
      check_window_readback();
   endtask

   // Returns once every queued sample has been taken and every result has arrived.
   task automatic wait_drained();
      while (samples_pending.size() != 0 || req_chan.valid || span_results_due.size() != 0)
         @(posedge clock);
      repeat (LATENCY_CYCLES + 2) @(posedge clock);
   endtask

   task automatic run_phase(input logic [APB_DATA_BITS-1:0] window, input int send_pct,
                            input int stall_pct, input int count);
      wait_drained();
      set_window(window);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) samples_pending.push_back(random_sample());
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.sample = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 0;
      error_count = 0;
      cycle_count = 0;
      sample_taken = 1'b0;
      window_len = WL_RESET;
      window_fill = '0;
      peak_hi = '0;
      peak_lo = sample_type'(MAX_SAMPLE);
      foreach (span_ring[i]) span_ring[i] = '0;
      ring_slot = 0;
      span_total = 0;

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // Two samples tracked under the reset window length.
      samples_pending.push_back(sample_type'(MAX_SAMPLE));
      samples_pending.push_back('0);
      wait_drained();

      // Empty window: the first sample closes the open window, later ones store zero.
      set_window(0);
      samples_pending.push_back(12'd100);
      samples_pending.push_back(sample_type'(MAX_SAMPLE));
      wait_drained();

      // A write to an unmapped register must leave the window length alone.
      csr_write(REG_UNMAPPED, 32'd7);
      check_window_readback();

      // Upper data bits are ignored; the closing samples are not tracked.
      set_window(32'h5A5A_0003);
      samples_pending.push_back('0);
      samples_pending.push_back(sample_type'(MAX_SAMPLE));
      samples_pending.push_back(12'd2048);
      samples_pending.push_back(12'd1);
      samples_pending.push_back(12'd2047);
      samples_pending.push_back(12'd2047);
      samples_pending.push_back(12'd2047);
      samples_pending.push_back('0);
      wait_drained();

      // Shortening the window below the current count closes it on the next sample.
      set_window(5);
      samples_pending.push_back(12'd10);
      samples_pending.push_back(12'd20);
      samples_pending.push_back(12'd30);
      wait_drained();
      set_window(2);
      samples_pending.push_back(12'd5);
      samples_pending.push_back(sample_type'(MAX_SAMPLE));
      wait_drained();

      run_phase(1, 0, 0, 200);
      run_phase($urandom_range(12, 2), 66, 0, 200);
      run_phase(0, 0, 66, 100);
      run_phase($urandom_range(40, 2), 6, 6, 250);

      // Back-pressure: results are held off while samples keep coming, so the
      // block fills and stalls its input; then the sender waits for a full drain.
      wait_drained();
      set_window(5);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 400;
      repeat (200) samples_pending.push_back(random_sample());
      wait_drained();
      repeat (50) samples_pending.push_back(random_sample());
      wait_drained();

      run_phase(65535, 6, 6, 100);
      run_phase(3, 0, 0, 100);

      repeat (LATENCY_CYCLES * 4) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
